FILE: src/pgn_pkg.sv
// Package for the greedy pose suppression block: widths, codes, beat and entry types.
`timescale 1ns / 1ps
package pgn_pkg;

  // Depth of the kept-pose store and the width of an address into it.
  localparam int KEEP_DEPTH = 64;
  localparam int IDX_W      = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;

  // Field widths.
  localparam int XY_W       = 24;
  localparam int ANG_W      = 16;
  localparam int SCL_W      = 16;
  localparam int LIMIT_W    = 7;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SQ_W       = 2 * XY_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Cycles from the last store read until its compare result is folded in.
  localparam int DRAIN_CYC = 4;
  localparam int DRAIN_W   = $clog2(DRAIN_CYC);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_THR   = 3'd5;

  // Input beat.
  typedef struct packed {
    logic signed [XY_W-1:0] pose_x;
    logic signed [XY_W-1:0] pose_y;
    logic [ANG_W-1:0]       pose_angle;
    logic [SCL_W-1:0]       pose_scale;
    logic                   first_pose;
  } pgn_in_t;

  // Result beat.
  typedef struct packed {
    logic             keep;
    logic [CNT_W-1:0] kept_index;
    logic [CNT_W-1:0] kept_count;
    logic [CNT_W-1:0] seen_count;
  } pgn_out_t;

  // One stored pose.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ANG_W-1:0]       angle;
    logic [SCL_W-1:0]       scale;
  } pgn_entry_t;

  // Threshold set handed to the compare unit.
  typedef struct packed {
    logic [XY_W-1:0]  trans;
    logic [ANG_W-1:0] angle;
    logic [SCL_W-1:0] scale;
  } pgn_thr_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } pgn_state_t;

endpackage

FILE: src/pgn_store.sv
// Kept-pose store: one write port and one registered read port.
`timescale 1ns / 1ps
module pgn_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [pgn_pkg::IDX_W-1:0] waddr,
  input  pgn_pkg::pgn_entry_t      wdata,
  input  logic                     re,
  input  logic [pgn_pkg::IDX_W-1:0] raddr,
  output logic                     rvld,
  output pgn_pkg::pgn_entry_t      rdata
);

  pgn_pkg::pgn_entry_t mem [pgn_pkg::KEEP_DEPTH];

  logic                rvld_r;
  pgn_pkg::pgn_entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Read data valid is the read strobe, registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= re;
    end
  end

  assign rvld  = rvld_r;
  assign rdata = rdata_r;

endmodule

FILE: src/pgn_cmp.sv
// Pipelined proximity test of the current pose against one stored pose per cycle.
`timescale 1ns / 1ps
module pgn_cmp (
  input  logic                clk,
  input  logic                rst_n,
  input  pgn_pkg::pgn_thr_t   thr,
  input  pgn_pkg::pgn_entry_t probe,
  input  logic                ent_vld,
  input  pgn_pkg::pgn_entry_t ent,
  output logic                hit_vld,
  output logic                hit
);

  localparam int DW = pgn_pkg::XY_W + 1;

  // Stage one: magnitudes of the differences.
  logic                          s1_vld_r;
  logic [pgn_pkg::XY_W-1:0]      s1_adx_r;
  logic [pgn_pkg::XY_W-1:0]      s1_ady_r;
  logic [pgn_pkg::ANG_W-1:0]     s1_da_r;
  logic [pgn_pkg::SCL_W-1:0]     s1_ds_r;
  // Stage two: squares and the angle and scale verdicts.
  logic                          s2_vld_r;
  logic [pgn_pkg::SQ_W-1:0]      s2_dx2_r;
  logic [pgn_pkg::SQ_W-1:0]      s2_dy2_r;
  logic                          s2_ang_ok_r;
  logic                          s2_scl_ok_r;
  // Stage three: final verdict.
  logic                          hit_vld_r;
  logic                          hit_r;
  // Squared translation threshold, refreshed every cycle.
  logic [pgn_pkg::SQ_W-1:0]      t2_r;

  logic [DW-1:0]                 dx;
  logic [DW-1:0]                 dy;
  logic [DW-1:0]                 adx;
  logic [DW-1:0]                 ady;
  logic [pgn_pkg::ANG_W-1:0]     da_raw;
  logic [pgn_pkg::ANG_W-1:0]     da_mag;
  logic [pgn_pkg::SCL_W-1:0]     ds;
  logic [pgn_pkg::SQ_W:0]        d2;

  // Differences in one bit more than the operands, then their magnitudes.
  always_comb begin
    dx     = {probe.x[pgn_pkg::XY_W-1], probe.x} - {ent.x[pgn_pkg::XY_W-1], ent.x};
    dy     = {probe.y[pgn_pkg::XY_W-1], probe.y} - {ent.y[pgn_pkg::XY_W-1], ent.y};
    adx    = dx[DW-1] ? (~dx + 1'b1) : dx;
    ady    = dy[DW-1] ? (~dy + 1'b1) : dy;
    // The angle difference wraps, so half a turn is the largest magnitude.
    da_raw = probe.angle - ent.angle;
    da_mag = da_raw[pgn_pkg::ANG_W-1] ? (~da_raw + 1'b1) : da_raw;
    ds     = (probe.scale >= ent.scale) ? (probe.scale - ent.scale)
                                        : (ent.scale - probe.scale);
  end

  always_ff @(posedge clk) begin
    s1_adx_r <= adx[pgn_pkg::XY_W-1:0];
    s1_ady_r <= ady[pgn_pkg::XY_W-1:0];
    s1_da_r  <= da_mag;
    s1_ds_r  <= ds;
  end

  always_ff @(posedge clk) begin
    s2_dx2_r    <= s1_adx_r * s1_adx_r;
    s2_dy2_r    <= s1_ady_r * s1_ady_r;
    s2_ang_ok_r <= s1_da_r < thr.angle;
    s2_scl_ok_r <= s1_ds_r < thr.scale;
    t2_r        <= thr.trans * thr.trans;
  end

  // Exact sum of squares, one bit wider so that it cannot wrap.
  assign d2 = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};

  always_ff @(posedge clk) begin
    hit_r <= (d2 < {1'b0, t2_r}) && s2_ang_ok_r && s2_scl_ok_r;
  end

  // Valid bits through the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      hit_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= ent_vld;
      s2_vld_r  <= s1_vld_r;
      hit_vld_r <= s2_vld_r;
    end
  end

  assign hit_vld = hit_vld_r;
  assign hit     = hit_r;

endmodule

FILE: src/pose_greedy_nms.sv
// Top level of the greedy pose suppression block: sequencer, counters and registers.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall   pgn_in_t   (one pose a beat)
//  out_     output     out_valid / out_stall pgn_out_t  (one result a beat)
//  cfg_     input      cfg_we                cfg_index, cfg_data
//
// A pose is taken while idle; then the n poses kept so far (at most KEEP_DEPTH - 1) are
// scanned: the store has one read port and is scanned one entry a cycle, and the store
// read register and the three compare stages lie between the last read and its verdict.
// A pose that needs no scan goes straight to the finish state. Reset (rst_n low,
// synchronous) clears counts and handshake state and resets configuration; the store is
// not cleared. The next pose is taken while a finished result waits under out_stall.
`timescale 1ns / 1ps
module pose_greedy_nms (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pgn_pkg::pgn_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pgn_pkg::pgn_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [pgn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgn_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [pgn_pkg::CNT_W-1:0] DEPTH_C = pgn_pkg::CNT_W'(pgn_pkg::KEEP_DEPTH);

  // Configuration registers.
  logic                        enable_r;
  logic [pgn_pkg::LIMIT_W-1:0] hard_limit_r;
  logic [pgn_pkg::LIMIT_W-1:0] target_limit_r;
  pgn_pkg::pgn_thr_t           thr_r;

  // Sequencer and item state.
  pgn_pkg::pgn_state_t          state_r;
  pgn_pkg::pgn_state_t          state_nxt;
  pgn_pkg::pgn_entry_t          probe_r;
  logic [pgn_pkg::CNT_W-1:0]    kept_total_r;
  logic [pgn_pkg::CNT_W-1:0]    seen_total_r;
  logic                         scan_ok_r;
  logic                         dup_r;
  logic [pgn_pkg::IDX_W-1:0]    scan_cnt_r;
  logic [pgn_pkg::IDX_W-1:0]    last_r;
  logic [pgn_pkg::DRAIN_W-1:0]  drain_cnt_r;
  logic                         out_valid_r;
  pgn_pkg::pgn_out_t            out_data_r;

  // Combinational helpers.
  logic                         in_acc;
  logic                         out_free;
  logic                         finish_go;
  logic [pgn_pkg::CNT_W-1:0]    kt_cur;
  logic [pgn_pkg::CNT_W-1:0]    seen_cur;
  logic [pgn_pkg::CNT_W-1:0]    seen_new;
  logic [pgn_pkg::CNT_W-1:0]    hard_lim;
  logic [pgn_pkg::CNT_W-1:0]    eff_lim;
  logic                         can_keep;
  logic                         keep_f;
  logic [pgn_pkg::CNT_W-1:0]    kt_next;
  logic                         st_we;
  logic                         rd_vld;
  pgn_pkg::pgn_entry_t          rd_data;
  logic                         hit_vld;
  logic                         hit;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b1;
      hard_limit_r   <= '0;
      target_limit_r <= '0;
      thr_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgn_pkg::REG_ENABLE:     enable_r       <= cfg_data[0];
        pgn_pkg::REG_HARD_LIMIT: hard_limit_r   <= cfg_data[pgn_pkg::LIMIT_W-1:0];
        pgn_pkg::REG_TARGET:     target_limit_r <= cfg_data[pgn_pkg::LIMIT_W-1:0];
        pgn_pkg::REG_TRANS_THR:  thr_r.trans    <= cfg_data[pgn_pkg::XY_W-1:0];
        pgn_pkg::REG_ANGLE_THR:  thr_r.angle    <= cfg_data[pgn_pkg::ANG_W-1:0];
        pgn_pkg::REG_SCALE_THR:  thr_r.scale    <= cfg_data[pgn_pkg::SCL_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes.
  assign in_stall  = (state_r != pgn_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign finish_go = (state_r == pgn_pkg::ST_FINISH) && out_free;

  // Counts as seen by an arriving pose, and the effective keep limit.
  always_comb begin
    kt_cur   = in_data.first_pose ? '0 : kept_total_r;
    seen_cur = in_data.first_pose ? '0 : seen_total_r;
    seen_new = (seen_cur == pgn_pkg::CNT_MAX) ? seen_cur : seen_cur + 1'b1;
    hard_lim = DEPTH_C;
    if ((hard_limit_r != '0) && (pgn_pkg::CNT_W'(hard_limit_r) < DEPTH_C)) begin
      hard_lim = pgn_pkg::CNT_W'(hard_limit_r);
    end
    eff_lim = hard_lim;
    if ((target_limit_r != '0) && (pgn_pkg::CNT_W'(target_limit_r) < hard_lim)) begin
      eff_lim = pgn_pkg::CNT_W'(target_limit_r);
    end
    can_keep = kt_cur < eff_lim;
  end

  // Verdict once the scan is over.
  always_comb begin
    keep_f  = !enable_r || (scan_ok_r && !dup_r);
    kt_next = kept_total_r;
    if (keep_f && (kept_total_r != pgn_pkg::CNT_MAX)) begin
      kt_next = kept_total_r + 1'b1;
    end
    st_we = finish_go && keep_f && (kept_total_r < DEPTH_C);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pgn_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (enable_r && can_keep && (kt_cur != '0)) begin
            state_nxt = pgn_pkg::ST_SCAN;
          end else begin
            state_nxt = pgn_pkg::ST_FINISH;
          end
        end
      end
      pgn_pkg::ST_SCAN: begin
        if (scan_cnt_r == last_r) begin
          state_nxt = pgn_pkg::ST_DRAIN;
        end
      end
      pgn_pkg::ST_DRAIN: begin
        if (drain_cnt_r == pgn_pkg::DRAIN_W'(pgn_pkg::DRAIN_CYC - 1)) begin
          state_nxt = pgn_pkg::ST_FINISH;
        end
      end
      pgn_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = pgn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pgn_pkg::ST_IDLE;
    endcase
  end

  // Pose capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      probe_r.x     <= in_data.pose_x;
      probe_r.y     <= in_data.pose_y;
      probe_r.angle <= in_data.pose_angle;
      probe_r.scale <= in_data.pose_scale;
      last_r        <= kt_cur[pgn_pkg::IDX_W-1:0] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r  <= '0;
      drain_cnt_r <= '0;
      scan_ok_r   <= 1'b0;
      dup_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        scan_cnt_r <= '0;
        scan_ok_r  <= can_keep;
      end else if (state_r == pgn_pkg::ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (state_r == pgn_pkg::ST_DRAIN) begin
        drain_cnt_r <= drain_cnt_r + 1'b1;
      end else begin
        drain_cnt_r <= '0;
      end
      // Any near stored pose marks the current one as a duplicate.
      if (in_acc) begin
        dup_r <= 1'b0;
      end else if (hit_vld && hit) begin
        dup_r <= 1'b1;
      end
    end
  end

  // List counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_total_r <= '0;
      seen_total_r <= '0;
    end else if (in_acc) begin
      kept_total_r <= kt_cur;
      seen_total_r <= seen_new;
    end else if (finish_go) begin
      kept_total_r <= kt_next;
    end
  end

  // Output register: loaded when the verdict is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_data_r.keep       <= keep_f;
      out_data_r.kept_index <= keep_f ? kept_total_r : '0;
      out_data_r.kept_count <= kt_next;
      out_data_r.seen_count <= seen_total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pgn_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (st_we),
    .waddr (kept_total_r[pgn_pkg::IDX_W-1:0]),
    .wdata (probe_r),
    .re    (state_r == pgn_pkg::ST_SCAN),
    .raddr (scan_cnt_r),
    .rvld  (rd_vld),
    .rdata (rd_data)
  );

  pgn_cmp u_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .thr     (thr_r),
    .probe   (probe_r),
    .ent_vld (rd_vld),
    .ent     (rd_data),
    .hit_vld (hit_vld),
    .hit     (hit)
  );

`ifndef SYNTH
  // A compare result only ever arrives while a scan is under way.
  a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    hit_vld |-> (state_r == pgn_pkg::ST_SCAN || state_r == pgn_pkg::ST_DRAIN))
    else $error("compare result outside a scan");

  // The scan address never runs past the last kept entry.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgn_pkg::ST_SCAN) |-> (scan_cnt_r <= last_r))
    else $error("scan address beyond kept entries");

  // A kept pose lies below the kept count unless the count has saturated.
  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.keep && out_data_r.kept_count != pgn_pkg::CNT_MAX)
      |-> (out_data_r.kept_index < out_data_r.kept_count))
    else $error("kept index not below kept count");
`endif

endmodule
